// File: src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Types, operation codes and constants shared by the deque cell row, the
// top level and its checker.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CAP_RESET = 16;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_STATUS     = 3'd4;

  typedef struct packed {
    logic [2:0]              operation;
    logic signed [VAL_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    empty_res;
    logic                    full_res;
  } cdq_out_t;

  // one-hot row command, at most one bit set per cycle
  typedef struct packed {
    logic shift_in;   // push front: every cell takes its left neighbor
    logic shift_out;  // pop front: every cell takes its right neighbor
    logic append;     // push back: first empty cell loads the push value
    logic drop;       // pop back: the rear cell goes empty
    logic clear;      // empty the whole row
  } cdq_ctl_t;

endpackage

// File: src/circular_deque.sv
// Results: a result strobes on out_valid in the cycle after its beat is accepted.
// Throughput: one operation per cycle; busy stays low, since every operation
// is a single update of the cell row.
// Reset (synchronous, rst_n low): deque empty, capacity 16 (clamped to DEPTH).
// A capacity write also empties the deque. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue built as a row of shifting cells: pushes and pops at
// the front shift the whole row, the rear end fills or empties in place.
// ----------------------------------------------------------------------------
module circular_deque #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  cdq_pkg::cdq_in_t                 in_data,
  output logic                             out_valid,
  output cdq_pkg::cdq_out_t                out_data,
  input  logic                             cfg_wr_en,
  input  logic [cdq_pkg::CAP_W-1:0]        cfg_wr_data
);
  import cdq_pkg::*;

  localparam int unsigned IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CAP_RST_EFF  = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;
  localparam logic [IDX_W-1:0] FULL_IDX_RST = IDX_W'(CAP_RST_EFF - 1);

  logic                    cell_valid [DEPTH];
  logic signed [VAL_W-1:0] cell_val   [DEPTH];
  logic [DEPTH-1:0]        is_rear;

  cdq_ctl_t         ctl;
  logic [IDX_W-1:0] full_idx_r;
  logic [IDX_W-1:0] full_idx_nxt;
  logic             out_valid_r;
  logic             ok_r;
  logic             ok_nxt;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic signed [VAL_W-1:0] rear_val;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_empty = !cell_valid[0];
  assign is_full  = cell_valid[full_idx_r];

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    lv;
    logic signed [VAL_W-1:0] ld;
    logic                    rv;
    logic signed [VAL_W-1:0] rd;

    if (i == 0) begin : g_head
      // the push value stands to the left of the front cell
      assign lv = 1'b1;
      assign ld = in_data.value;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign ld = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign rd = '0;
    end else begin : g_body
      assign rv = cell_valid[i+1];
      assign rd = cell_val[i+1];
    end

    assign is_rear[i] = cell_valid[i] && !rv;

    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .push_val    (in_data.value),
      .left_valid  (lv),
      .left_val    (ld),
      .right_valid (rv),
      .right_val   (rd),
      .valid       (cell_valid[i]),
      .val         (cell_val[i])
    );
  end

  // operation decode
  always_comb begin
    ctl    = '0;
    ok_nxt = 1'b0;
    if (cfg_wr_en) begin
      ctl.clear = 1'b1;
    end else if (accept) begin
      unique case (in_data.operation)
        OP_PUSH_FRONT: begin
          ok_nxt       = !is_full;
          ctl.shift_in = !is_full;
        end
        OP_PUSH_BACK: begin
          ok_nxt     = !is_full;
          ctl.append = !is_full;
        end
        OP_POP_FRONT: begin
          ok_nxt        = !is_empty;
          ctl.shift_out = !is_empty;
        end
        OP_POP_BACK: begin
          ok_nxt   = !is_empty;
          ctl.drop = !is_empty;
        end
        OP_STATUS: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // capacity kept as the index of the last usable cell
  always_comb begin
    full_idx_nxt = full_idx_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        full_idx_nxt = '0;
      end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
        full_idx_nxt = IDX_W'(DEPTH - 1);
      end else begin
        full_idx_nxt = IDX_W'(cfg_wr_data - CAP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_idx_r  <= FULL_IDX_RST;
      out_valid_r <= 1'b0;
    end else begin
      full_idx_r  <= full_idx_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  // rear select: only one cell is the rear
  always_comb begin
    rear_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (is_rear[i]) begin
        rear_val = rear_val | cell_val[i];
      end
    end
  end

  // status is read from the row after the update of the accepted beat
  assign out_valid            = out_valid_r;
  assign out_data.ok          = ok_r;
  assign out_data.front_value = is_empty ? '1 : cell_val[0];
  assign out_data.rear_value  = is_empty ? '1 : rear_val;
  assign out_data.empty_res   = is_empty;
  assign out_data.full_res    = is_full;

endmodule

// File: src/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the deque row. Holds a value and a valid bit and moves data
// to or from its neighbors as the row command says.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cdq_pkg::cdq_ctl_t                ctl,
  input  logic signed [cdq_pkg::VAL_W-1:0] push_val,
  input  logic                             left_valid,
  input  logic signed [cdq_pkg::VAL_W-1:0] left_val,
  input  logic                             right_valid,
  input  logic signed [cdq_pkg::VAL_W-1:0] right_val,
  output logic                             valid,
  output logic signed [cdq_pkg::VAL_W-1:0] val
);
  import cdq_pkg::*;

  logic                    valid_r;
  logic                    valid_nxt;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  always_comb begin
    valid_nxt = valid_r;
    val_nxt   = val_r;
    priority if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift_in) begin
      valid_nxt = left_valid;
      val_nxt   = left_val;
    end else if (ctl.shift_out) begin
      valid_nxt = right_valid;
      val_nxt   = right_val;
    end else if (ctl.append) begin
      // first empty slot behind the rear
      if (!valid_r && left_valid) begin
        valid_nxt = 1'b1;
        val_nxt   = push_val;
      end
    end else if (ctl.drop) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign valid = valid_r;
  assign val   = val_r;

endmodule

// File: src/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks on the deque: result timing, empty reporting and the
// clearing effect of a capacity write.
// ----------------------------------------------------------------------------
module cdq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input cdq_pkg::cdq_in_t   in_data,
  input logic               out_valid,
  input cdq_pkg::cdq_out_t  out_data,
  input logic               cfg_wr_en
);
  import cdq_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted beat gave no result in the next cycle");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result strobe without an accepted beat");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.empty_res) |->
      (out_data.front_value == '1 && out_data.rear_value == '1 && !out_data.full_res))
    else $error("empty deque reported values or full");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en ##1 (start && !busy && in_data.operation == OP_STATUS))
      |=> (out_valid && out_data.empty_res && out_data.ok))
    else $error("capacity write did not empty the deque");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
